### hdl/wavhc_pkg.sv
// Package with the word types and result record shared by the WAV header locator modules.
`timescale 1ns / 1ps

package wavhc_pkg;

  // Status codes carried in a result word.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [31:0] data_length;
    logic [31:0] data_start;
  } out_t;

  // A result word from the parser together with its strobe.
  typedef struct packed {
    logic valid;
    out_t word;
  } res_t;

endpackage

### hdl/wavhc_parser.sv
// Parser state registers and the one-byte step logic of the WAV header locator.
`timescale 1ns / 1ps

module wavhc_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  wavhc_pkg::in_t  word,
  output wavhc_pkg::res_t res
);

  localparam logic [31:0] TAG_WAVE     = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT      = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA     = 32'h6461_7461;
  localparam logic [31:0] MIN_FMT_BODY = 32'd16;

  typedef enum logic [2:0] {
    PH_WAVE,
    PH_FMT,
    PH_FMTSIZE,
    PH_BODY,
    PH_DATA,
    PH_DATASIZE,
    PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] tag_window, tag_window_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] field_counter, field_counter_next;
  logic [31:0] format_length, format_length_next;
  logic [15:0] held_channels, held_channels_next;
  logic [31:0] held_rate, held_rate_next;
  logic [15:0] held_bits, held_bits_next;
  logic [31:0] held_data_length, held_data_length_next;

  logic [31:0] win_shift;
  logic [31:0] lane_byte;
  logic [4:0]  lane_shift;
  logic [31:0] counter_inc;

  assign win_shift   = {tag_window[23:0], word.file_byte};
  assign lane_byte   = {24'h000000, word.file_byte};
  assign lane_shift  = {field_counter[1:0], 3'b000};
  assign counter_inc = field_counter + 32'd1;

  always_comb begin
    phase_next            = phase;
    tag_window_next       = win_shift;
    byte_position_next    = byte_position + 32'd1;
    field_counter_next    = field_counter;
    format_length_next    = format_length;
    held_channels_next    = held_channels;
    held_rate_next        = held_rate;
    held_bits_next        = held_bits;
    held_data_length_next = held_data_length;
    res                   = '0;

    unique case (phase)
      PH_WAVE: begin
        if (win_shift == TAG_WAVE) phase_next = PH_FMT;
      end
      PH_FMT: begin
        if (win_shift == TAG_FMT) begin
          phase_next         = PH_FMTSIZE;
          field_counter_next = '0;
          format_length_next = '0;
        end
      end
      PH_FMTSIZE: begin
        format_length_next = format_length | (lane_byte << lane_shift);
        field_counter_next = counter_inc;
        if (field_counter[1:0] == 2'd3) begin
          field_counter_next = '0;
          if (format_length_next < MIN_FMT_BODY) begin
            res.valid       = 1'b1;
            res.word.status = wavhc_pkg::STATUS_ERR;
            phase_next      = PH_DONE;
          end else begin
            phase_next = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (field_counter == 32'd2) held_channels_next = held_channels | {8'h00, word.file_byte};
        else if (field_counter == 32'd3) held_channels_next = held_channels | {word.file_byte, 8'h00};
        else if (field_counter[31:2] == 30'd1) held_rate_next = held_rate | (lane_byte << lane_shift);
        else if (field_counter == 32'd14) held_bits_next = held_bits | {8'h00, word.file_byte};
        else if (field_counter == 32'd15) held_bits_next = held_bits | {word.file_byte, 8'h00};
        field_counter_next = counter_inc;
        // The body length is at least 16 here, so the count meets it exactly.
        if (counter_inc == format_length) begin
          field_counter_next = '0;
          tag_window_next    = '0;
          phase_next         = PH_DATA;
        end
      end
      PH_DATA: begin
        if (win_shift == TAG_DATA) begin
          phase_next            = PH_DATASIZE;
          field_counter_next    = '0;
          held_data_length_next = '0;
        end
      end
      PH_DATASIZE: begin
        held_data_length_next = held_data_length | (lane_byte << lane_shift);
        field_counter_next    = counter_inc;
        if (field_counter[1:0] == 2'd3) begin
          field_counter_next     = '0;
          res.valid              = 1'b1;
          res.word.status        = wavhc_pkg::STATUS_OK;
          res.word.channel_count = held_channels;
          res.word.sample_rate   = held_rate;
          res.word.sample_bits   = held_bits;
          res.word.data_length   = held_data_length_next;
          res.word.data_start    = byte_position + 32'd1;
          phase_next             = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    // The final byte of a file closes any unfinished search with an error and rearms.
    if (word.last_byte) begin
      if (!res.valid && (phase_next < PH_DONE)) begin
        res.valid       = 1'b1;
        res.word        = '0;
        res.word.status = wavhc_pkg::STATUS_ERR;
      end
      phase_next            = PH_WAVE;
      tag_window_next       = '0;
      byte_position_next    = '0;
      field_counter_next    = '0;
      format_length_next    = '0;
      held_channels_next    = '0;
      held_rate_next        = '0;
      held_bits_next        = '0;
      held_data_length_next = '0;
    end

    if (!go) res.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_WAVE;
      tag_window       <= '0;
      byte_position    <= '0;
      field_counter    <= '0;
      format_length    <= '0;
      held_channels    <= '0;
      held_rate        <= '0;
      held_bits        <= '0;
      held_data_length <= '0;
    end else if (go) begin
      phase            <= phase_next;
      tag_window       <= tag_window_next;
      byte_position    <= byte_position_next;
      field_counter    <= field_counter_next;
      format_length    <= format_length_next;
      held_channels    <= held_channels_next;
      held_rate        <= held_rate_next;
      held_bits        <= held_bits_next;
      held_data_length <= held_data_length_next;
    end
  end

endmodule

### hdl/wavhc_out_queue.sv
// Result register with a skid stage on the header output channel.
`timescale 1ns / 1ps

module wavhc_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  wavhc_pkg::res_t  res,
  output logic             skid_full,
  output logic             valid,
  input  logic             stall,
  output wavhc_pkg::out_t  word
);

  logic            skid_valid;
  wavhc_pkg::out_t skid_word;
  logic            out_free;

  // The output register can take a new word when it is empty or being read.
  assign out_free  = !valid || !stall;
  assign skid_full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        valid      <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        valid <= res.valid;
      end
    end else if (res.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) word <= skid_word;
      else if (res.valid) word <= res.word;
    end else if (res.valid) begin
      skid_word <= res.word;
    end
  end

endmodule

### hdl/wav_header_chunk_locator.sv
// Top level of the WAV header locator: input register, parser and output queue.
`timescale 1ns / 1ps

// Takes a WAV file one byte per word on the byte channel, with last_byte set on the
// final byte, and gives one header word per file on the hdr channel: channel count,
// sample rate, bits per sample, data chunk length and the offset of the first sound
// byte, or status 1 with all other fields zero when the format chunk is shorter than
// 16 bytes or the file ends before the data chunk size is read. A byte is taken in
// every cycle in which byte_stall is low; each byte is held in the input register and
// its result, if any, is registered in the output register or its skid stage. Input
// stalls only while both the output register and its skid stage hold words that the
// hdr side has not taken. After a final byte the parser starts over for the next file.

module wav_header_chunk_locator (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  output logic            byte_stall,
  input  wavhc_pkg::in_t  byte_word,
  output logic            hdr_valid,
  input  logic            hdr_stall,
  output wavhc_pkg::out_t hdr_word
);

  logic            s1_valid;
  wavhc_pkg::in_t  s1_word;
  logic            s1_go;
  logic            skid_full;
  wavhc_pkg::res_t res;

  // The staged byte is stepped whenever the skid stage has room for a result.
  assign s1_go      = s1_valid && !skid_full;
  assign byte_stall = s1_valid && skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) s1_word <= byte_word;
  end

  wavhc_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .go   (s1_go),
    .word (s1_word),
    .res  (res)
  );

  wavhc_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .skid_full (skid_full),
    .valid     (hdr_valid),
    .stall     (hdr_stall),
    .word      (hdr_word)
  );

endmodule

### hdl/wavhc_checker.sv
// Port-level assertions for the WAV header locator and the bind that attaches them.
`timescale 1ns / 1ps

module wavhc_checker (
  input logic            clk,
  input logic            rst,
  input logic            byte_valid,
  input logic            byte_stall,
  input wavhc_pkg::in_t  byte_word,
  input logic            hdr_valid,
  input logic            hdr_stall,
  input wavhc_pkg::out_t hdr_word
);

  a_hdr_hold: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && hdr_stall |=> hdr_valid)
    else $error("header word dropped while stalled");

  a_hdr_stable: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && hdr_stall |=> $stable(hdr_word))
    else $error("header word changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && (hdr_word.status == wavhc_pkg::STATUS_ERR) |->
      (hdr_word.channel_count == '0) && (hdr_word.sample_rate == '0) &&
      (hdr_word.sample_bits == '0) && (hdr_word.data_length == '0) &&
      (hdr_word.data_start == '0))
    else $error("error word carries nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !hdr_valid)
    else $error("header word present after reset");

  // A stalled byte word has to stay offered and unchanged until it is taken.
  a_byte_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(byte_word))
    else $error("byte word changed while stalled");

endmodule

bind wav_header_chunk_locator wavhc_checker u_wavhc_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .byte_word  (byte_word),
  .hdr_valid  (hdr_valid),
  .hdr_stall  (hdr_stall),
  .hdr_word   (hdr_word)
);
